FILE: src/bpc_pkg.sv
package bpc_pkg;

    localparam int RegIdxW = 2;
    localparam int CfgW    = 48;

    typedef enum logic [RegIdxW-1:0] {
        REG_TEMP    = 2'd0,
        REG_PRESS_A = 2'd1,
        REG_PRESS_B = 2'd2,
        REG_PRESS_C = 2'd3
    } reg_idx_t;

    // calibration words; t1 and p1 unsigned, the rest two's complement
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } coef_t;

    // fields that ride alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic        pvalid;
    } side_t;

endpackage

FILE: src/baro_temp_pressure_compensation_unit.sv
// The pipeline has 10 front stages, 66 divider stages and 5 back stages between
// request accept and result valid.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on m_tready. Reset (aresetn, synchronous, active low) clears the
// pipeline valid bits and all calibration registers to zero.
module baro_temp_pressure_compensation_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // temp_adc[19:0], press_adc[39:20]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32]
    output logic [0:0]           m_tuser,   // pressure_valid[0]
    input  logic                 cfg_wen,
    input  logic [bpc_pkg::RegIdxW-1:0] cfg_addr,
    input  logic [bpc_pkg::CfgW-1:0]    cfg_wdata
);
    import bpc_pkg::*;

    logic [CfgW-1:0] tc_reg;
    logic [CfgW-1:0] pa_reg;
    logic [CfgW-1:0] pb_reg;
    logic [CfgW-1:0] pc_reg;
    coef_t           coef;
    logic            en;

    logic            f_valid;
    logic [31:0]     f_temp;
    logic [63:0]     f_num;
    logic [63:0]     f_den;
    logic            f_pvalid;
    side_t           f_side;
    logic            d_valid;
    logic [63:0]     d_quo;
    side_t           d_side;
    logic [31:0]     b_temp;
    logic [31:0]     b_press;
    logic            b_pvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= '0;
        end else if (cfg_wen) begin
            case (reg_idx_t'(cfg_addr))
                REG_TEMP:    tc_reg <= cfg_wdata;
                REG_PRESS_A: pa_reg <= cfg_wdata;
                REG_PRESS_B: pb_reg <= cfg_wdata;
                REG_PRESS_C: pc_reg <= cfg_wdata;
                default:     tc_reg <= tc_reg;
            endcase
        end
    end

    assign coef = '{t1: tc_reg[15:0], t2: tc_reg[31:16], t3: tc_reg[47:32],
                    p1: pa_reg[15:0], p2: pa_reg[31:16], p3: pa_reg[47:32],
                    p4: pb_reg[15:0], p5: pb_reg[31:16], p6: pb_reg[47:32],
                    p7: pc_reg[15:0], p8: pc_reg[31:16], p9: pc_reg[47:32]};

    // advance everything unless the output holds an untaken result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign f_side = '{temp: f_temp, pvalid: f_pvalid};

    bpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .raw_t     (s_tdata[19:0]),
        .raw_p     (s_tdata[39:20]),
        .coef      (coef),
        .out_valid (f_valid),
        .temp      (f_temp),
        .num       (f_num),
        .den       (f_den),
        .pvalid    (f_pvalid)
    );

    bpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side_in   (f_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .side_out  (d_side)
    );

    bpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .p         (d_quo),
        .side_in   (d_side),
        .coef      (coef),
        .out_valid (m_tvalid),
        .temp      (b_temp),
        .press     (b_press),
        .pvalid    (b_pvalid)
    );

    assign m_tdata = {b_press, b_temp};
    assign m_tuser = b_pvalid;

endmodule

FILE: src/bpc_front.sv
module bpc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [19:0]    raw_t,
    input  logic [19:0]    raw_p,
    input  bpc_pkg::coef_t coef,
    output logic           out_valid,
    output logic [31:0]    temp,
    output logic [63:0]    num,
    output logic [63:0]    den,
    output logic           pvalid
);
    import bpc_pkg::*;

    logic [9:0]         vld_reg;
    logic [19:0]        ap_reg [1:8];
    logic [31:0]        tmp_reg [5:10];
    logic signed [18:0] x1_reg;
    logic signed [16:0] d1_reg;
    logic [31:0]        xt2_reg;
    logic [31:0]        dd2_reg;
    logic signed [20:0] v13_reg;
    logic [31:0]        m3_reg;
    logic [31:0]        tf4_reg;
    logic signed [33:0] a5_reg;
    logic [63:0]        aa6_reg;
    logic signed [49:0] ap5_6_reg;
    logic signed [49:0] ap2_6_reg;
    logic [63:0]        bm7_reg;
    logic [63:0]        am7_reg;
    logic signed [49:0] ap5_7_reg;
    logic signed [49:0] ap2_7_reg;
    logic [63:0]        b8_reg;
    logic [63:0]        a8_reg;
    logic [63:0]        c9_reg;
    logic [63:0]        nb9_reg;
    logic [63:0]        num_reg;
    logic [63:0]        den_reg;
    logic               pv_reg;

    logic signed [34:0] xt2_w;
    logic signed [33:0] dd_w;
    logic signed [19:0] dds_w;
    logic signed [35:0] m3_w;
    logic [31:0]        t5_w;
    logic signed [67:0] aa_w;
    logic signed [49:0] ap5_w;
    logic signed [49:0] ap2_w;
    logic signed [79:0] bm_w;
    logic signed [79:0] am_w;
    logic [63:0]        cbase_w;
    logic [79:0]        c_w;
    logic [20:0]        p0_w;
    logic [75:0]        n_w;

    assign xt2_w   = x1_reg * $signed(coef.t2);
    assign dd_w    = d1_reg * d1_reg;
    assign dds_w   = $signed(dd2_reg[31:12]);
    assign m3_w    = dds_w * $signed(coef.t3);
    assign t5_w    = tf4_reg + {tf4_reg[29:0], 2'b00} + 32'd128;
    assign aa_w    = a5_reg * a5_reg;
    assign ap5_w   = a5_reg * $signed(coef.p5);
    assign ap2_w   = a5_reg * $signed(coef.p2);
    assign bm_w    = $signed(aa6_reg) * $signed(coef.p6);
    assign am_w    = $signed(aa6_reg) * $signed(coef.p3);
    assign cbase_w = a8_reg + 64'h0000_8000_0000_0000;
    assign c_w     = cbase_w * coef.p1;
    assign p0_w    = 21'd1048576 - {1'b0, ap_reg[8]};
    assign n_w     = nb9_reg * 12'd3125;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ap_reg[1] <= raw_p;
            for (int k = 2; k <= 8; k++) begin
                ap_reg[k] <= ap_reg[k-1];
            end
            // temperature path wraps at 32 bits
            x1_reg  <= $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
            d1_reg  <= $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coef.t1});
            xt2_reg <= xt2_w[31:0];
            dd2_reg <= dd_w[31:0];
            v13_reg <= $signed(xt2_reg[31:11]);
            m3_reg  <= m3_w[31:0];
            tf4_reg <= {{11{v13_reg[20]}}, v13_reg} + {{14{m3_reg[31]}}, m3_reg[31:14]};
            tmp_reg[5] <= {{8{t5_w[31]}}, t5_w[31:8]};
            for (int k = 6; k <= 10; k++) begin
                tmp_reg[k] <= tmp_reg[k-1];
            end
            // pressure path wraps at 64 bits
            a5_reg    <= $signed({{2{tf4_reg[31]}}, tf4_reg}) - 34'sd128000;
            aa6_reg   <= aa_w[63:0];
            ap5_6_reg <= ap5_w;
            ap2_6_reg <= ap2_w;
            bm7_reg   <= bm_w[63:0];
            am7_reg   <= am_w[63:0];
            ap5_7_reg <= ap5_6_reg;
            ap2_7_reg <= ap2_6_reg;
            b8_reg    <= bm7_reg + ({{14{ap5_7_reg[49]}}, ap5_7_reg} << 17)
                         + ({{48{coef.p4[15]}}, coef.p4} << 35);
            a8_reg    <= {{8{am7_reg[63]}}, am7_reg[63:8]}
                         + ({{14{ap2_7_reg[49]}}, ap2_7_reg} << 12);
            c9_reg    <= c_w[63:0];
            nb9_reg   <= {12'b0, p0_w, 31'b0} - b8_reg;
            num_reg   <= n_w[63:0];
            den_reg   <= {{33{c9_reg[63]}}, c9_reg[63:33]};
            pv_reg    <= |c9_reg[63:33];
        end
    end

    assign out_valid = vld_reg[9];
    assign temp      = tmp_reg[10];
    assign num       = num_reg;
    assign den       = den_reg;
    assign pvalid    = pv_reg;

endmodule

FILE: src/bpc_div.sv
module bpc_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [63:0]    num,
    input  logic [63:0]    den,
    input  bpc_pkg::side_t side_in,
    output logic           out_valid,
    output logic [63:0]    quo,
    output bpc_pkg::side_t side_out
);
    import bpc_pkg::*;

    logic [65:0] vld_reg;
    logic [63:0] rem_reg [0:64];
    logic [63:0] qn_reg  [0:64];
    logic [63:0] dv_reg  [0:64];
    logic        neg_reg [0:64];
    side_t       sd_reg  [0:64];
    logic [63:0] quo_reg;
    side_t       sdo_reg;
    logic [64:0] diff_w  [1:64];

    // one quotient bit per stage, restoring
    always_comb begin
        for (int k = 1; k <= 64; k++) begin
            diff_w[k] = {1'b0, rem_reg[k-1][62:0], qn_reg[k-1][63]} - {1'b0, dv_reg[k-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[64:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            qn_reg[0]  <= num[63] ? (64'd0 - num) : num;
            dv_reg[0]  <= den[63] ? (64'd0 - den) : den;
            neg_reg[0] <= num[63] ^ den[63];
            sd_reg[0]  <= side_in;
            for (int k = 1; k <= 64; k++) begin
                rem_reg[k] <= diff_w[k][64] ? {rem_reg[k-1][62:0], qn_reg[k-1][63]}
                                            : diff_w[k][63:0];
                qn_reg[k]  <= {qn_reg[k-1][62:0], ~diff_w[k][64]};
                dv_reg[k]  <= dv_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sd_reg[k]  <= sd_reg[k-1];
            end
            quo_reg <= neg_reg[64] ? (64'd0 - qn_reg[64]) : qn_reg[64];
            sdo_reg <= sd_reg[64];
        end
    end

    assign out_valid = vld_reg[65];
    assign quo       = quo_reg;
    assign side_out  = sdo_reg;

endmodule

FILE: src/bpc_back.sv
module bpc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [63:0]    p,
    input  bpc_pkg::side_t side_in,
    input  bpc_pkg::coef_t coef,
    output logic           out_valid,
    output logic [31:0]    temp,
    output logic [31:0]    press,
    output logic           pvalid
);
    import bpc_pkg::*;

    logic [4:0]  vld_reg;
    side_t       sd_reg [1:4];
    logic [63:0] p1_reg;
    logic [63:0] ps1_reg;
    logic [63:0] m1_reg;
    logic [63:0] m2_reg;
    logic [63:0] p2_reg;
    logic [63:0] m2b_reg;
    logic [63:0] pp0_reg;
    logic [31:0] pp1_reg;
    logic [31:0] pp2_reg;
    logic [63:0] p3_reg;
    logic [63:0] prod_reg;
    logic [63:0] b3_reg;
    logic [63:0] s4_reg;
    logic [31:0] temp_reg;
    logic [31:0] press_reg;
    logic        pv_reg;

    logic [63:0]        ps_w;
    logic signed [79:0] m1_w;
    logic signed [79:0] m2_w;
    logic [63:0]        pp1_w;
    logic [63:0]        pp2_w;

    assign ps_w  = {{13{p[63]}}, p[63:13]};
    assign m1_w  = $signed(coef.p9) * $signed(ps_w);
    assign m2_w  = $signed(coef.p8) * $signed(p);
    // low 64 bits of m1 * ps from 32-bit partial products
    assign pp1_w = m1_reg[31:0] * ps1_reg[63:32];
    assign pp2_w = m1_reg[63:32] * ps1_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[1] <= side_in;
            for (int k = 2; k <= 4; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
            p1_reg   <= p;
            ps1_reg  <= ps_w;
            m1_reg   <= m1_w[63:0];
            m2_reg   <= m2_w[63:0];
            p2_reg   <= p1_reg;
            m2b_reg  <= m2_reg;
            pp0_reg  <= m1_reg[31:0] * ps1_reg[31:0];
            pp1_reg  <= pp1_w[31:0];
            pp2_reg  <= pp2_w[31:0];
            p3_reg   <= p2_reg;
            prod_reg <= pp0_reg + {pp1_reg + pp2_reg, 32'b0};
            b3_reg   <= {{19{m2b_reg[63]}}, m2b_reg[63:19]};
            s4_reg   <= p3_reg + {{25{prod_reg[63]}}, prod_reg[63:25]} + b3_reg;
            temp_reg <= sd_reg[4].temp;
            pv_reg   <= sd_reg[4].pvalid;
            // zero divisor: force pressure to zero
            press_reg <= sd_reg[4].pvalid
                         ? (s4_reg[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'b0000})
                         : 32'd0;
        end
    end

    assign out_valid = vld_reg[4];
    assign temp      = temp_reg;
    assign press     = press_reg;
    assign pvalid    = pv_reg;

endmodule
